@@ src/mtsl_pkg.sv @@
// Shared types and constants of the multi-table sorted id lookup.
// Used by every module in src but mtsl_ram; depends on nothing else.
package mtsl_pkg;

    // Number of archive slots and entries per slot table.
    localparam int ARCHIVES = 4;
    localparam int ENTRIES  = 1024;

    // Field widths of the request and the tables.
    localparam int SLOT_W  = 2;
    localparam int ENTRY_W = 10;
    localparam int CNT_W   = 11;
    localparam int WORD_W  = 32;
    localparam int ADDR_W  = SLOT_W + ENTRY_W;
    localparam int DEPTH   = ARCHIVES * ENTRIES;

    // One table row holds {length, offset, id}.
    localparam int ROW_W = 3 * WORD_W;

    // Packed stream widths.
    localparam int S_DATA_W = 192;
    localparam int M_DATA_W = 72;

    // Request kinds carried on s_tuser.
    typedef enum logic [1:0] {
        ACT_SET    = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_LOOKUP = 2'd2
    } action_t;

    // Lookup sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLOT,
        ST_PROBE,
        ST_DONE
    } state_t;

    // Archive descriptor as held per slot.
    typedef struct packed {
        logic              present;
        logic [CNT_W-1:0]  entries;
        logic [WORD_W-1:0] base;
        logic              resident;
    } desc_t;

endpackage

@@ src/mtsl_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package needed.
module mtsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/mtsl_desc.sv @@
// Archive descriptor file: one descriptor per slot, cleared at reset.
// Depends on mtsl_pkg.
module mtsl_desc (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [mtsl_pkg::SLOT_W-1:0] wr_slot,
    input  mtsl_pkg::desc_t        wr_desc,
    input  logic [mtsl_pkg::SLOT_W-1:0] rd_slot,
    output mtsl_pkg::desc_t        rd_desc
);
    import mtsl_pkg::*;

    desc_t desc_reg [ARCHIVES];

    // Descriptor registers, written by set requests.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ARCHIVES; i++)
            begin
                desc_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            desc_reg[wr_slot] <= wr_desc;
        end
    end

    assign rd_desc = desc_reg[rd_slot];

endmodule

@@ src/mtsl_engine.sv @@
// Lookup sequencer: walks the present slots and runs a count-halving binary
// search over the table RAM, one probe per cycle. Holds the result register.
// Depends on mtsl_pkg.
module mtsl_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mtsl_pkg::WORD_W-1:0] hash,
    output logic                        idle,
    output logic [mtsl_pkg::SLOT_W-1:0] slot,
    input  mtsl_pkg::desc_t             desc,
    output logic [mtsl_pkg::ADDR_W-1:0] raddr,
    input  logic [mtsl_pkg::ROW_W-1:0]  rdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic                        found,
    output logic [mtsl_pkg::SLOT_W-1:0] hit_archive,
    output logic [mtsl_pkg::WORD_W-1:0] location,
    output logic [mtsl_pkg::WORD_W-1:0] hit_length,
    output logic                        hit_resident
);
    import mtsl_pkg::*;

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [CNT_W-1:0]   base_reg, base_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   mid_reg, mid_next;
    logic [WORD_W-1:0]  hash_reg;

    // Pending result, moved to the output register when it is free.
    logic               res_found_reg, res_found_next;
    logic [WORD_W-1:0]  res_loc_reg, res_loc_next;
    logic [WORD_W-1:0]  res_len_reg, res_len_next;
    logic               res_resident_reg, res_resident_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;

    // Output register.
    logic               m_valid_reg;
    logic               found_reg;
    logic [SLOT_W-1:0]  hit_archive_reg;
    logic [WORD_W-1:0]  location_reg;
    logic [WORD_W-1:0]  hit_length_reg;
    logic               hit_resident_reg;

    logic               out_free;
    logic [WORD_W-1:0]  row_id;
    logic [WORD_W-1:0]  row_offset;
    logic [WORD_W-1:0]  row_length;
    logic               id_le;
    logic               id_eq;
    logic [CNT_W-1:0]   half;
    logic               last_slot;

    assign row_id     = rdata[WORD_W-1:0];
    assign row_offset = rdata[2*WORD_W-1:WORD_W];
    assign row_length = rdata[3*WORD_W-1:2*WORD_W];
    assign id_le      = $signed(row_id) <= $signed(hash_reg);
    assign id_eq      = row_id == hash_reg;
    assign half       = rem_reg >> 1;
    assign last_slot  = slot_reg == SLOT_W'(ARCHIVES - 1);
    assign out_free   = !m_valid_reg || m_tready;

    // Next state, search bookkeeping and the probe address.
    always_comb
    begin
        state_next        = state_reg;
        slot_next         = slot_reg;
        base_next         = base_reg;
        rem_next          = rem_reg;
        mid_next          = mid_reg;
        res_found_next    = res_found_reg;
        res_loc_next      = res_loc_reg;
        res_len_next      = res_len_reg;
        res_resident_next = res_resident_reg;
        res_slot_next     = res_slot_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    slot_next         = '0;
                    res_found_next    = 1'b0;
                    res_loc_next      = '0;
                    res_len_next      = '0;
                    res_resident_next = 1'b0;
                    res_slot_next     = '0;
                    state_next        = ST_SLOT;
                end
            end
            ST_SLOT:
            begin
                // Start a search in this slot, or skip it when absent or empty.
                if (desc.present && (desc.entries != '0))
                begin
                    base_next  = '0;
                    rem_next   = desc.entries;
                    mid_next   = desc.entries >> 1;
                    state_next = ST_PROBE;
                end
                else if (last_slot)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_PROBE:
            begin
                // The row at mid_reg is on rdata this cycle.
                if (id_eq)
                begin
                    res_found_next    = 1'b1;
                    res_loc_next      = desc.resident ? row_offset : row_offset + desc.base;
                    res_len_next      = row_length;
                    res_resident_next = desc.resident;
                    res_slot_next     = slot_reg;
                    state_next        = ST_DONE;
                end
                else
                begin
                    if (id_le)
                    begin
                        base_next = mid_reg + 1'b1;
                        rem_next  = rem_reg - 1'b1 - half;
                    end
                    else
                    begin
                        rem_next = half;
                    end
                    mid_next = base_next + (rem_next >> 1);
                    if (rem_next == '0)
                    begin
                        if (last_slot)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            slot_next  = slot_reg + 1'b1;
                            state_next = ST_SLOT;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The read address follows the next probe, so its row is on rdata when that probe is made.
    assign raddr = {slot_reg, mid_next[ENTRY_W-1:0]};
    assign slot  = slot_reg;
    assign idle  = state_reg == ST_IDLE;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Search and result payload registers.
    always_ff @(posedge clk)
    begin
        slot_reg         <= slot_next;
        base_reg         <= base_next;
        rem_reg          <= rem_next;
        mid_reg          <= mid_next;
        res_found_reg    <= res_found_next;
        res_loc_reg      <= res_loc_next;
        res_len_reg      <= res_len_next;
        res_resident_reg <= res_resident_next;
        res_slot_reg     <= res_slot_next;
        if (start && state_reg == ST_IDLE)
        begin
            hash_reg <= hash;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            found_reg        <= res_found_reg;
            hit_archive_reg  <= res_slot_reg;
            location_reg     <= res_loc_reg;
            hit_length_reg   <= res_len_reg;
            hit_resident_reg <= res_resident_reg;
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign found        = found_reg;
    assign hit_archive  = hit_archive_reg;
    assign location     = location_reg;
    assign hit_length   = hit_length_reg;
    assign hit_resident = hit_resident_reg;

    // A lookup only starts while the sequencer is idle.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == ST_IDLE)
        else $error("lookup started while busy");

    // A probe always has entries left to search.
    a_probe_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PROBE |-> rem_reg != '0)
        else $error("probe with empty range");

    // The search window stays inside the slot's table.
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PROBE |->
            ({1'b0, base_reg} + {1'b0, rem_reg}) <= {1'b0, desc.entries})
        else $error("search window beyond table");

    // A finished lookup lands in the output register.
    a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && out_free |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("result not delivered");

endmodule

@@ src/multi_table_sorted_id_lookup.sv @@
// Sorted id lookup over several archive tables: request decode, descriptor
// file, table RAM and lookup sequencer. Depends on mtsl_pkg, mtsl_ram,
// mtsl_desc and mtsl_engine.
//
// Requests arrive on the s_ stream; s_tuser carries the kind (set descriptor,
// load table entry, lookup hash). Set and load give no result. A lookup visits
// the present slots in order with a binary search in each, each probe one
// read of the table RAM; the first exact hit ends it. One lookup is in work at
// a time. The result goes to an output register on the m_ stream, m_tuser
// being the found flag. A new request is taken while that result still waits;
// if the receiver stalls, the next lookup finishes and holds until the
// register frees. Reset clears the descriptors (no slot present) and the
// control state; the table RAM is not cleared and must be loaded before it is
// searched.
module multi_table_sorted_id_lookup (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action
    input  logic [1:0]                      s_tuser,
    // archive_index, entry_index, entry_id, entry_offset, entry_length,
    // archive_present, archive_entries, archive_base, archive_resident,
    // lookup_hash, zero pad
    input  logic [mtsl_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // found
    output logic                            m_tuser,
    // hit_archive, location, hit_length, hit_resident, zero pad
    output logic [mtsl_pkg::M_DATA_W-1:0]   m_tdata
);
    import mtsl_pkg::*;

    action_t            action;
    logic [SLOT_W-1:0]  archive_index;
    logic [ENTRY_W-1:0] entry_index;
    logic [WORD_W-1:0]  entry_id;
    logic [WORD_W-1:0]  entry_offset;
    logic [WORD_W-1:0]  entry_length;
    logic               archive_present;
    logic [CNT_W-1:0]   archive_entries;
    logic [WORD_W-1:0]  archive_base;
    logic               archive_resident;
    logic [WORD_W-1:0]  lookup_hash;

    logic               accept;
    logic               slot_ok;
    logic               set_en;
    logic               load_en;
    logic               start;
    logic               idle;
    desc_t              wr_desc;
    desc_t              rd_desc;
    logic [SLOT_W-1:0]  rd_slot;
    logic [ADDR_W-1:0]  raddr;
    logic [ROW_W-1:0]   rdata;

    logic               found;
    logic [SLOT_W-1:0]  hit_archive;
    logic [WORD_W-1:0]  location;
    logic [WORD_W-1:0]  hit_length;
    logic               hit_resident;

    // Unpack the request.
    assign action           = action_t'(s_tuser);
    assign archive_index    = s_tdata[1:0];
    assign entry_index      = s_tdata[11:2];
    assign entry_id         = s_tdata[43:12];
    assign entry_offset     = s_tdata[75:44];
    assign entry_length     = s_tdata[107:76];
    assign archive_present  = s_tdata[108];
    assign archive_entries  = s_tdata[119:109];
    assign archive_base     = s_tdata[151:120];
    assign archive_resident = s_tdata[152];
    assign lookup_hash      = s_tdata[184:153];

    // Decode the request kind; out-of-range slots and entries are ignored.
    assign s_tready = idle;
    assign accept   = s_tvalid && s_tready;
    assign slot_ok  = 32'(archive_index) < ARCHIVES;
    always_comb
    begin
        set_en  = 1'b0;
        load_en = 1'b0;
        start   = 1'b0;
        case (action)
            ACT_SET:    set_en  = accept && slot_ok;
            ACT_LOAD:   load_en = accept && slot_ok && (32'(entry_index) < ENTRIES);
            ACT_LOOKUP: start   = accept;
            default:    ;
        endcase
    end

    // Entry counts above the table size saturate when stored.
    always_comb
    begin
        wr_desc.present  = archive_present;
        wr_desc.entries  = (32'(archive_entries) > ENTRIES) ? CNT_W'(ENTRIES)
                                                            : archive_entries;
        wr_desc.base     = archive_base;
        wr_desc.resident = archive_resident;
    end

    mtsl_desc u_desc (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (set_en),
        .wr_slot (archive_index),
        .wr_desc (wr_desc),
        .rd_slot (rd_slot),
        .rd_desc (rd_desc)
    );

    // Table RAM rows are {length, offset, id}; loads and lookups never overlap.
    mtsl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (load_en),
        .waddr ({archive_index, entry_index}),
        .wdata ({entry_length, entry_offset, entry_id}),
        .raddr (raddr),
        .rdata (rdata)
    );

    mtsl_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .hash         (lookup_hash),
        .idle         (idle),
        .slot         (rd_slot),
        .desc         (rd_desc),
        .raddr        (raddr),
        .rdata        (rdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .found        (found),
        .hit_archive  (hit_archive),
        .location     (location),
        .hit_length   (hit_length),
        .hit_resident (hit_resident)
    );

    // Pack the result.
    assign m_tuser = found;
    assign m_tdata = {5'd0, hit_resident, hit_length, location, hit_archive};

endmodule
